@@ sv/stereo_disparity_backprojection_unit_macros.svh @@
// Assertion macros for the stereo disparity back-projection unit.
// Included by the port checker; needs aclk and aresetn in scope.
`ifndef STEREO_DISPARITY_BACKPROJECTION_UNIT_MACROS_SVH
`define STEREO_DISPARITY_BACKPROJECTION_UNIT_MACROS_SVH

// Same-cycle implication, idle in reset
`define SDB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sdb port check failed");

// Next-cycle implication, idle in reset
`define SDB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sdb port check failed");

// Next-cycle implication, also checked through reset
`define SDB_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("sdb reset check failed");

`endif

@@ sv/sdb_pkg.sv @@
// Shared types, constants and width helpers of the back-projection unit.
// No dependencies; imported by the queue, front, back, top level and testbench.
`default_nettype none

package sdb_pkg;

    localparam int PIX_FRAC_BITS  = 4;
    localparam int BASE_FRAC_BITS = 16;
    localparam int COORD_W        = 16;
    localparam int DISP_W         = 16;
    localparam int FOCAL_W        = 16;
    localparam int BASE_W         = 18;
    localparam int MAP_W          = 13;
    localparam int LIMIT_W        = 11;
    localparam int POINT_W        = 32;
    localparam int MAG_W          = 16;
    localparam int PROD_W         = POINT_W + MAG_W;
    localparam int LAT_NUM_W      = PROD_W + 2;
    localparam int LAT_DEN_W      = FOCAL_W + 1;
    localparam int RAW_NUM_W      = FOCAL_W + 1 + BASE_W;
    localparam int RAW_DEN_W      = DISP_W + 2;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_W    = 2;

    localparam logic [POINT_W-1:0] S32_MAX = {1'b0, {(POINT_W-1){1'b1}}};
    localparam logic [POINT_W-1:0] S32_MIN = {1'b1, {(POINT_W-1){1'b0}}};

    typedef enum logic [2:0] {
        REG_FOCAL_X     = 3'd0,
        REG_FOCAL_Y     = 3'd1,
        REG_CENTER_X    = 3'd2,
        REG_CENTER_Y    = 3'd3,
        REG_BASELINE    = 3'd4,
        REG_MAP_WIDTH   = 3'd5,
        REG_MAP_HEIGHT  = 3'd6,
        REG_RANGE_LIMIT = 3'd7
    } reg_idx_t;

    // Classification of one keypoint, handed from front to back
    typedef struct packed {
        logic oob;
        logic zinf;
        logic dzero;
        logic zneg;
        logic dxneg;
        logic dyneg;
    } sdb_flags_t;

    function automatic int frac_shift(input int depth_fb, input int disp_fb);
        return depth_fb + disp_fb - PIX_FRAC_BITS - BASE_FRAC_BITS;
    endfunction

    function automatic int num_shl(input int depth_fb, input int disp_fb);
        int sh;
        sh = frac_shift(depth_fb, disp_fb);
        return (sh > 0) ? sh : 0;
    endfunction

    function automatic int den_shr(input int depth_fb, input int disp_fb);
        int sh;
        sh = frac_shift(depth_fb, disp_fb);
        return (sh < 0) ? -sh : 0;
    endfunction

    // Width of (2*num + den), the rounded-division dividend
    function automatic int divn_w(input int depth_fb, input int disp_fb);
        return RAW_NUM_W + num_shl(depth_fb, disp_fb) + 2;
    endfunction

    // Width of 2*den, the rounded-division divisor
    function automatic int divd_w(input int depth_fb, input int disp_fb);
        return RAW_DEN_W + den_shr(depth_fb, disp_fb) + 1;
    endfunction

endpackage

`default_nettype wire

@@ sv/sdb_fifo.sv @@
// Short queue between the classifying front and the arithmetic back.
// Uses sdb_pkg for its depth.
`default_nettype none

module sdb_fifo #(
    parameter int W = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    input  wire logic         pop,
    output logic              full,
    output logic              not_empty,
    output logic [W-1:0]      head
);
    import sdb_pkg::*;

    logic [W-1:0]           entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg;

    assign full      = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    // advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    // store entry
    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

@@ sv/sdb_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// Standalone; the whole pipe advances on en.
`default_nettype none

module sdb_div #(
    parameter int NW = 37,
    parameter int DW = 19,
    parameter int PW = 1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] in_num,
    input  wire logic [DW-1:0] in_den,
    input  wire logic [PW-1:0] in_pay,
    output logic               out_valid,
    output logic [NW-1:0]      out_quot,
    output logic [PW-1:0]      out_pay
);
    logic [NW-1:0] vld_reg;
    logic [DW-1:0] rem_reg  [NW];
    logic [NW-1:0] work_reg [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [PW-1:0] pay_reg  [NW];

    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic          vi;
        logic [DW-1:0] ri;
        logic [NW-1:0] wi;
        logic [DW-1:0] di;
        logic [PW-1:0] pi;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        if (s == 0) begin : g_first
            assign vi = in_valid;
            assign ri = '0;
            assign wi = in_num;
            assign di = in_den;
            assign pi = in_pay;
        end else begin : g_rest
            assign vi = vld_reg[s-1];
            assign ri = rem_reg[s-1];
            assign wi = work_reg[s-1];
            assign di = den_reg[s-1];
            assign pi = pay_reg[s-1];
        end

        // trial subtract of the next dividend bit
        assign trial = {ri, wi[NW-1]};
        assign diff  = trial - {1'b0, di};
        assign ge    = (trial >= {1'b0, di});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vi;
            end
        end

        // shift quotient bit in as dividend bits leave
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                work_reg[s] <= {wi[NW-2:0], ge};
                den_reg[s]  <= di;
                pay_reg[s]  <= pi;
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign out_quot  = work_reg[NW-1];
    assign out_pay   = pay_reg[NW-1];

endmodule

`default_nettype wire

@@ sv/sdb_front.sv @@
// Front end: bounds check, disparity repair, depth dividend/divisor setup and principal-point offsets.
// Uses sdb_pkg; purely combinational, feeds the queue.
`default_nettype none

module sdb_front #(
    parameter int DISP_FRAC_BITS  = 4,
    parameter int DEPTH_FRAC_BITS = 16
) (
    input  wire logic signed [15:0] coord_x,
    input  wire logic signed [15:0] coord_y,
    input  wire logic signed [15:0] disp_center,
    input  wire logic signed [15:0] disp_left,
    input  wire logic signed [15:0] disp_up,
    input  wire logic signed [15:0] disp_right,
    input  wire logic signed [15:0] disp_down,
    input  wire logic [15:0]        focal_x,
    input  wire logic [15:0]        focal_y,
    input  wire logic [15:0]        center_x,
    input  wire logic [15:0]        center_y,
    input  wire logic [17:0]        baseline,
    input  wire logic [12:0]        map_width,
    input  wire logic [12:0]        map_height,
    input  wire logic [10:0]        range_limit,
    output sdb_pkg::sdb_flags_t     flags,
    output logic [sdb_pkg::divn_w(DEPTH_FRAC_BITS, DISP_FRAC_BITS)-1:0] div_num,
    output logic [sdb_pkg::divd_w(DEPTH_FRAC_BITS, DISP_FRAC_BITS)-1:0] div_den,
    output logic [15:0]             dx_mag,
    output logic [15:0]             dy_mag
);
    import sdb_pkg::*;

    localparam int SHL    = num_shl(DEPTH_FRAC_BITS, DISP_FRAC_BITS);
    localparam int SHR    = den_shr(DEPTH_FRAC_BITS, DISP_FRAC_BITS);
    localparam int NUM_W  = RAW_NUM_W + SHL;
    localparam int DEN_W  = RAW_DEN_W + SHR;
    localparam int DIVN_W = divn_w(DEPTH_FRAC_BITS, DISP_FRAC_BITS);
    localparam int CMP_W  = (LIMIT_W + 1 + DISP_FRAC_BITS > DISP_W + 1) ?
                            LIMIT_W + 1 + DISP_FRAC_BITS : DISP_W + 1;
    localparam logic signed [17:0] PIX_ONE = 18'sd1 <<< PIX_FRAC_BITS;

    logic signed [17:0]      cx_e, cy_e, wlim_e, hlim_e, dx, dy, nsum;
    logic signed [CMP_W-1:0] dc_e, lim_e;
    logic                    has_l, has_u, has_r, has_d, bad;
    logic signed [15:0]      disp_sel;
    logic                    disp_neg;
    logic [16:0]             disp_mag;
    logic [16:0]             focal_sum;
    logic [RAW_NUM_W-1:0]    num_raw;
    logic [NUM_W-1:0]        num_sh;
    logic [DEN_W-1:0]        den_sh;

    always_comb begin
        cx_e   = {{2{coord_x[15]}}, coord_x};
        cy_e   = {{2{coord_y[15]}}, coord_y};
        wlim_e = 18'({map_width, {PIX_FRAC_BITS{1'b0}}});
        hlim_e = 18'({map_height, {PIX_FRAC_BITS{1'b0}}});

        // neighbour availability
        has_l = (cx_e >= PIX_ONE);
        has_u = (cy_e >= PIX_ONE);
        has_r = ((cx_e + PIX_ONE) < wlim_e);
        has_d = ((cy_e + PIX_ONE) < hlim_e);

        // replace a bad centre disparity by a quarter of the available neighbours' sum
        dc_e  = CMP_W'(disp_center);
        lim_e = signed'(CMP_W'(range_limit) << DISP_FRAC_BITS);
        bad   = (dc_e <= 0) || (dc_e > lim_e);
        nsum  = '0;
        if (has_l) nsum = nsum + {{2{disp_left[15]}}, disp_left};
        if (has_u) nsum = nsum + {{2{disp_up[15]}}, disp_up};
        if (has_r) nsum = nsum + {{2{disp_right[15]}}, disp_right};
        if (has_d) nsum = nsum + {{2{disp_down[15]}}, disp_down};
        disp_sel = bad ? nsum[17:2] : disp_center;
        disp_neg = disp_sel[15];
        disp_mag = disp_neg ? 17'(-{disp_sel[15], disp_sel}) : {1'b0, disp_sel};

        // depth = (fx+fy)*baseline / (2*disp), rounded: (2n+d)/(2d)
        focal_sum = {1'b0, focal_x} + {1'b0, focal_y};
        num_raw   = RAW_NUM_W'(focal_sum) * RAW_NUM_W'(baseline);
        num_sh    = NUM_W'(num_raw) << SHL;
        den_sh    = DEN_W'({disp_mag, 1'b0}) << SHR;
        div_num   = DIVN_W'({num_sh, 1'b0}) + DIVN_W'(den_sh);
        div_den   = {den_sh, 1'b0};

        // offsets from the principal point
        dx     = cx_e - signed'({2'b00, center_x});
        dy     = cy_e - signed'({2'b00, center_y});
        dx_mag = dx[17] ? 16'(-dx) : dx[15:0];
        dy_mag = dy[17] ? 16'(-dy) : dy[15:0];

        flags.oob   = cx_e[17] || (cx_e >= wlim_e) || cy_e[17] || (cy_e >= hlim_e);
        flags.dzero = (disp_mag == '0);
        flags.zinf  = flags.dzero && (num_raw != '0);
        flags.zneg  = disp_neg;
        flags.dxneg = dx[17];
        flags.dyneg = dy[17];
    end

endmodule

`default_nettype wire

@@ sv/sdb_back.sv @@
// Back end: depth divider, saturation, lateral multiply and dividers, output register.
// Uses sdb_pkg and sdb_div.
`default_nettype none

module sdb_back #(
    parameter int DEPTH_FRAC_BITS = 16,
    parameter int DIVN_W          = 37,
    parameter int DIVD_W          = 19
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire sdb_pkg::sdb_flags_t in_flags,
    input  wire logic [DIVN_W-1:0]   in_num,
    input  wire logic [DIVD_W-1:0]   in_den,
    input  wire logic [15:0]         in_dx_mag,
    input  wire logic [15:0]         in_dy_mag,
    input  wire logic [15:0]         focal_x,
    input  wire logic [15:0]         focal_y,
    input  wire logic [10:0]         range_limit,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [31:0]              point_x,
    output logic [31:0]              point_y,
    output logic [31:0]              point_z,
    output logic                     point_valid
);
    import sdb_pkg::*;

    localparam int DPW = $bits(sdb_flags_t) + 2 * MAG_W;
    localparam int LPW = POINT_W + 3;
    localparam logic [DIVN_W-1:0] MIN_DEPTH_RAW =
        DIVN_W'(((64'd1 << DEPTH_FRAC_BITS) + 64'd999) / 64'd1000);

    function automatic logic [POINT_W-1:0] sat_lat(input logic [LAT_NUM_W-1:0] q,
                                                   input logic neg);
        logic big;
        big = (q[LAT_NUM_W-1:POINT_W-1] != '0);
        if (neg) return big ? S32_MIN : POINT_W'(-q[POINT_W-1:0]);
        return big ? S32_MAX : q[POINT_W-1:0];
    endfunction

    logic                 en;
    logic                 out_vld_reg;
    logic [POINT_W-1:0]   out_x_reg, out_y_reg, out_z_reg;
    logic                 out_pv_reg;

    // depth divider outputs
    logic                 zd_valid;
    logic [DIVN_W-1:0]    zd_quot;
    logic [DPW-1:0]       zd_pay;
    sdb_flags_t           zd_flags;
    logic [MAG_W-1:0]     zd_dxm, zd_dym;

    // depth stage
    logic [POINT_W-1:0]   z_next;
    logic                 zv_next, zbig;
    logic [DIVN_W-1:0]    zlim;
    logic                 zs_vld_reg;
    logic [POINT_W-1:0]   zs_z_reg;
    logic                 zs_valid_reg, zs_oob_reg, zs_dxneg_reg, zs_dyneg_reg;
    logic [MAG_W-1:0]     zs_dxm_reg, zs_dym_reg;

    // multiply stage
    logic [POINT_W-1:0]   zabs;
    logic [FOCAL_W-1:0]   fx1, fy1;
    logic [PROD_W-1:0]    px, py;
    logic                 ms_vld_reg;
    logic [LAT_NUM_W-1:0] ms_nx_reg, ms_ny_reg;
    logic [POINT_W-1:0]   ms_z_reg;
    logic                 ms_valid_reg, ms_oob_reg, ms_negx_reg, ms_negy_reg;

    // lateral divider outputs
    logic                 xd_valid, yd_valid;
    logic [LAT_NUM_W-1:0] xd_quot, yd_quot;
    logic [LPW-1:0]       xd_pay;
    logic                 yd_pay;
    logic [POINT_W-1:0]   xd_z;
    logic                 xd_pv, xd_oob, xd_neg;

    // advance the whole back pipe when the output register frees up
    assign en       = !out_vld_reg || m_ready;
    assign in_ready = en;

    sdb_div #(.NW(DIVN_W), .DW(DIVD_W), .PW(DPW)) u_zdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_valid),
        .in_num    (in_num),
        .in_den    (in_den),
        .in_pay    ({in_flags, in_dx_mag, in_dy_mag}),
        .out_valid (zd_valid),
        .out_quot  (zd_quot),
        .out_pay   (zd_pay)
    );

    assign {zd_flags, zd_dxm, zd_dym} = zd_pay;

    // saturate depth and judge validity on the full quotient
    always_comb begin
        zlim = DIVN_W'(range_limit) << DEPTH_FRAC_BITS;
        zbig = (zd_quot[DIVN_W-1:POINT_W-1] != '0);
        if (zd_flags.dzero) begin
            z_next = zd_flags.zinf ? S32_MAX : '0;
        end else if (zd_flags.zneg) begin
            z_next = zbig ? S32_MIN : POINT_W'(-zd_quot[POINT_W-1:0]);
        end else begin
            z_next = zbig ? S32_MAX : zd_quot[POINT_W-1:0];
        end
        zv_next = !zd_flags.dzero && !zd_flags.zneg &&
                  (zd_quot >= MIN_DEPTH_RAW) && (zd_quot <= zlim);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zs_vld_reg <= 1'b0;
        end else if (en) begin
            zs_vld_reg <= zd_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zs_z_reg     <= z_next;
            zs_valid_reg <= zv_next;
            zs_oob_reg   <= zd_flags.oob;
            zs_dxneg_reg <= zd_flags.dxneg;
            zs_dyneg_reg <= zd_flags.dyneg;
            zs_dxm_reg   <= zd_dxm;
            zs_dym_reg   <= zd_dym;
        end
    end

    // lateral dividend 2*|z|*|d| + f for rounded division by f
    always_comb begin
        zabs = zs_z_reg[POINT_W-1] ? POINT_W'(-zs_z_reg) : zs_z_reg;
        fx1  = (focal_x == '0) ? FOCAL_W'(1) : focal_x;
        fy1  = (focal_y == '0) ? FOCAL_W'(1) : focal_y;
        px   = PROD_W'(zabs) * PROD_W'(zs_dxm_reg);
        py   = PROD_W'(zabs) * PROD_W'(zs_dym_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ms_vld_reg <= 1'b0;
        end else if (en) begin
            ms_vld_reg <= zs_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ms_nx_reg    <= LAT_NUM_W'({px, 1'b0}) + LAT_NUM_W'(fx1);
            ms_ny_reg    <= LAT_NUM_W'({py, 1'b0}) + LAT_NUM_W'(fy1);
            ms_z_reg     <= zs_z_reg;
            ms_valid_reg <= zs_valid_reg;
            ms_oob_reg   <= zs_oob_reg;
            ms_negx_reg  <= zs_z_reg[POINT_W-1] ^ zs_dxneg_reg;
            ms_negy_reg  <= zs_z_reg[POINT_W-1] ^ zs_dyneg_reg;
        end
    end

    sdb_div #(.NW(LAT_NUM_W), .DW(LAT_DEN_W), .PW(LPW)) u_xdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (ms_vld_reg),
        .in_num    (ms_nx_reg),
        .in_den    ({fx1, 1'b0}),
        .in_pay    ({ms_z_reg, ms_valid_reg, ms_oob_reg, ms_negx_reg}),
        .out_valid (xd_valid),
        .out_quot  (xd_quot),
        .out_pay   (xd_pay)
    );

    sdb_div #(.NW(LAT_NUM_W), .DW(LAT_DEN_W), .PW(1)) u_ydiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (ms_vld_reg),
        .in_num    (ms_ny_reg),
        .in_den    ({fy1, 1'b0}),
        .in_pay    (ms_negy_reg),
        .out_valid (yd_valid),
        .out_quot  (yd_quot),
        .out_pay   (yd_pay)
    );

    assign {xd_z, xd_pv, xd_oob, xd_neg} = xd_pay;

    // output register; out-of-map points give all zeros
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= xd_valid && yd_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_x_reg  <= xd_oob ? '0 : sat_lat(xd_quot, xd_neg);
            out_y_reg  <= xd_oob ? '0 : sat_lat(yd_quot, yd_pay);
            out_z_reg  <= xd_oob ? '0 : xd_z;
            out_pv_reg <= !xd_oob && xd_pv;
        end
    end

    assign m_valid     = out_vld_reg;
    assign point_x     = out_x_reg;
    assign point_y     = out_y_reg;
    assign point_z     = out_z_reg;
    assign point_valid = out_pv_reg;

endmodule

`default_nettype wire

@@ sv/stereo_disparity_backprojection_unit.sv @@
// Top level of the stereo disparity back-projection unit: registers, front, queue, back.
// Depends on sdb_pkg, sdb_front, sdb_fifo, sdb_back.
`default_nettype none

// Turns one keypoint (coordinates plus centre and four neighbour disparities) into a
// camera-frame point and a valid flag. One keypoint is taken per clock cycle while the
// queue is not full. Each result passes through the queue, the depth divider (DIVN_W
// stages), a saturation stage, a multiply stage, the x/y dividers (50 stages each) and
// the output register; the dividers are restoring pipelines, one quotient bit per stage.
// A four-entry queue between classification and arithmetic absorbs output stalls.
// Configuration registers may only be rewritten while the unit is empty.
module stereo_disparity_backprojection_unit #(
    parameter int DISP_FRAC_BITS  = 4,
    parameter int DEPTH_FRAC_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // coord_x, coord_y, disp_center, disp_left, disp_up, disp_right, disp_down
    input  wire logic [111:0] s_tdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // point_x, point_y, point_z
    output logic [95:0]       m_tdata,
    // point_valid
    output logic              m_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import sdb_pkg::*;

    localparam int DIVN_W = divn_w(DEPTH_FRAC_BITS, DISP_FRAC_BITS);
    localparam int DIVD_W = divd_w(DEPTH_FRAC_BITS, DISP_FRAC_BITS);
    localparam int QW     = $bits(sdb_flags_t) + DIVN_W + DIVD_W + 2 * MAG_W;

    logic [15:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic [17:0] baseline_reg;
    logic [12:0] map_width_reg, map_height_reg;
    logic [10:0] range_limit_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    sdb_flags_t        fr_flags, bk_flags;
    logic [DIVN_W-1:0] fr_num, bk_num;
    logic [DIVD_W-1:0] fr_den, bk_den;
    logic [15:0]       fr_dxm, fr_dym, bk_dxm, bk_dym;
    logic [QW-1:0]     q_head;
    logic              q_full, q_not_empty, push, pop, bk_ready;

    // register file
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg     <= 16'd11502;
            focal_y_reg     <= 16'd11502;
            center_x_reg    <= 16'd9715;
            center_y_reg    <= 16'd2963;
            baseline_reg    <= 18'd35203;
            map_width_reg   <= 13'd1241;
            map_height_reg  <= 13'd376;
            range_limit_reg <= 11'd1000;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FOCAL_X:     focal_x_reg     <= pwdata[15:0];
                REG_FOCAL_Y:     focal_y_reg     <= pwdata[15:0];
                REG_CENTER_X:    center_x_reg    <= pwdata[15:0];
                REG_CENTER_Y:    center_y_reg    <= pwdata[15:0];
                REG_BASELINE:    baseline_reg    <= pwdata[17:0];
                REG_MAP_WIDTH:   map_width_reg   <= pwdata[12:0];
                REG_MAP_HEIGHT:  map_height_reg  <= pwdata[12:0];
                REG_RANGE_LIMIT: range_limit_reg <= pwdata[10:0];
                default:         focal_x_reg     <= focal_x_reg;
            endcase
        end
    end

    // register read-back
    always_comb begin
        unique case (cfg_idx)
            REG_FOCAL_X:     prdata = 32'(focal_x_reg);
            REG_FOCAL_Y:     prdata = 32'(focal_y_reg);
            REG_CENTER_X:    prdata = 32'(center_x_reg);
            REG_CENTER_Y:    prdata = 32'(center_y_reg);
            REG_BASELINE:    prdata = 32'(baseline_reg);
            REG_MAP_WIDTH:   prdata = 32'(map_width_reg);
            REG_MAP_HEIGHT:  prdata = 32'(map_height_reg);
            REG_RANGE_LIMIT: prdata = 32'(range_limit_reg);
            default:         prdata = '0;
        endcase
    end

    sdb_front #(
        .DISP_FRAC_BITS  (DISP_FRAC_BITS),
        .DEPTH_FRAC_BITS (DEPTH_FRAC_BITS)
    ) u_front (
        .coord_x     (s_tdata[15:0]),
        .coord_y     (s_tdata[31:16]),
        .disp_center (s_tdata[47:32]),
        .disp_left   (s_tdata[63:48]),
        .disp_up     (s_tdata[79:64]),
        .disp_right  (s_tdata[95:80]),
        .disp_down   (s_tdata[111:96]),
        .focal_x     (focal_x_reg),
        .focal_y     (focal_y_reg),
        .center_x    (center_x_reg),
        .center_y    (center_y_reg),
        .baseline    (baseline_reg),
        .map_width   (map_width_reg),
        .map_height  (map_height_reg),
        .range_limit (range_limit_reg),
        .flags       (fr_flags),
        .div_num     (fr_num),
        .div_den     (fr_den),
        .dx_mag      (fr_dxm),
        .dy_mag      (fr_dym)
    );

    // queue a classified keypoint on each input transfer
    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;
    assign pop      = q_not_empty && bk_ready;

    sdb_fifo #(.W(QW)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({fr_flags, fr_num, fr_den, fr_dxm, fr_dym}),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    assign {bk_flags, bk_num, bk_den, bk_dxm, bk_dym} = q_head;

    sdb_back #(
        .DEPTH_FRAC_BITS (DEPTH_FRAC_BITS),
        .DIVN_W          (DIVN_W),
        .DIVD_W          (DIVD_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (q_not_empty),
        .in_ready    (bk_ready),
        .in_flags    (bk_flags),
        .in_num      (bk_num),
        .in_den      (bk_den),
        .in_dx_mag   (bk_dxm),
        .in_dy_mag   (bk_dym),
        .focal_x     (focal_x_reg),
        .focal_y     (focal_y_reg),
        .range_limit (range_limit_reg),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .point_x     (m_tdata[31:0]),
        .point_y     (m_tdata[63:32]),
        .point_z     (m_tdata[95:64]),
        .point_valid (m_tuser)
    );

endmodule

`default_nettype wire

@@ sv/sdb_checker.sv @@
// Port-level checks of the back-projection unit, bound to the top level.
// Depends on the unit's macro header.
`default_nettype none

`include "stereo_disparity_backprojection_unit_macros.svh"

module sdb_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata,
    input wire logic        m_tuser
);
    // a stalled result transfer holds its contents
    `SDB_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // a valid point has positive, nonzero depth
    `SDB_ASSERT_IMP(a_valid_depth, m_tvalid && m_tuser, !m_tdata[95] && (m_tdata[95:64] != 32'd0))
    // zero depth gives zero lateral offsets
    `SDB_ASSERT_IMP(a_zero_depth, m_tvalid && (m_tdata[95:64] == 32'd0), m_tdata[63:0] == 64'd0)
    // reset empties the pipe and opens the input
    `SDB_ASSERT_RST(a_reset_empty, !aresetn, !m_tvalid && s_tready)
endmodule

bind stereo_disparity_backprojection_unit sdb_checker u_sdb_checker (.*);

`default_nettype wire

@@ dv/tb_stereo_disparity_backprojection_unit.sv @@
// Testbench of the stereo disparity back-projection unit: directed table, then random keypoints.
// Depends on sdb_pkg and stereo_disparity_backprojection_unit; checks each point against a predictor.
`default_nettype none

module tb_stereo_disparity_backprojection_unit;
    import sdb_pkg::*;

    localparam int DRAIN_CYCLES = 200;
    localparam int DEPTH_FB     = 16;
    localparam int DISP_FB      = 4;

    typedef struct packed {
        logic signed [15:0] disp_down;
        logic signed [15:0] disp_right;
        logic signed [15:0] disp_up;
        logic signed [15:0] disp_left;
        logic signed [15:0] disp_center;
        logic signed [15:0] coord_y;
        logic signed [15:0] coord_x;
    } keypoint_t;

    typedef struct packed {
        logic        point_valid;
        logic [31:0] point_z;
        logic [31:0] point_y;
        logic [31:0] point_x;
    } point_t;

    typedef struct {
        keypoint_t kp;
        logic      has_point;
        point_t    pt;
    } directed_row_t;

    logic         aclk;
    logic         aresetn;
    logic [111:0] s_tdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  m_tdata;
    logic         m_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // Predictor copy of the register file
    logic [15:0] cfg_fx, cfg_fy, cfg_cx, cfg_cy;
    logic [17:0] cfg_base;
    logic [12:0] cfg_width, cfg_height;
    logic [10:0] cfg_limit;

    point_t pending_points[$];
    int     mismatches;
    bit     rx_quiet;

    stereo_disparity_backprojection_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #40000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [63:0] round_div(input logic [63:0] num, input logic [63:0] den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic logic signed [63:0] sat32(input logic [63:0] mag, input logic neg);
        if (neg)
            return (mag >= 64'h8000_0000) ? -64'sh8000_0000 : -$signed(mag);
        return (mag > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : $signed(mag);
    endfunction

    function automatic logic signed [63:0] lateral_offset(input logic signed [63:0] z,
            input logic signed [63:0] d, input logic [15:0] focal);
        logic [63:0] zm, dm, f;
        zm = (z < 0) ? -z : z;
        dm = (d < 0) ? -d : d;
        f  = (focal == 0) ? 64'd1 : 64'(focal);
        return sat32(round_div(zm * dm, f), (z < 0) != (d < 0));
    endfunction

    // Back-project one keypoint with the current register values
    function automatic point_t backproject(input keypoint_t kp);
        logic signed [63:0] cx, cy, disp, wlim, hlim, sum, z, x, y;
        logic [63:0] num, den, zmag;
        logic zneg, zinf, valid;
        int sh;
        point_t pt;
        cx = kp.coord_x;
        cy = kp.coord_y;
        disp = kp.disp_center;
        wlim = 64'(cfg_width) << 4;
        hlim = 64'(cfg_height) << 4;
        sh = DEPTH_FB + DISP_FB - 4 - 16;
        zmag = 0;
        zinf = 1'b0;
        pt = '0;
        if (cx < 0 || cx >= wlim || cy < 0 || cy >= hlim)
            return pt;
        // Replace a bad centre disparity by a quarter of the available neighbours' sum
        if (disp <= 0 || disp > (64'(cfg_limit) << DISP_FB)) begin
            sum = 0;
            if (cx >= 16) sum += kp.disp_left;
            if (cy >= 16) sum += kp.disp_up;
            if (cx + 16 < wlim) sum += kp.disp_right;
            if (cy + 16 < hlim) sum += kp.disp_down;
            disp = sum >>> 2;
        end
        num = (64'(cfg_fx) + 64'(cfg_fy)) * 64'(cfg_base);
        zneg = disp < 0;
        den = 2 * ((disp < 0) ? -disp : disp);
        if (sh >= 0) num = num << sh;
        else den = den << (-sh);
        if (den == 0) begin
            zinf = num != 0;
            zneg = 1'b0;
            z = zinf ? 64'sh7FFF_FFFF : 64'sd0;
        end else begin
            zmag = round_div(num, den);
            z = sat32(zmag, zneg);
        end
        valid = !zinf && !zneg && zmag >= ((64'd1 << DEPTH_FB) + 999) / 1000 &&
                zmag <= (64'(cfg_limit) << DEPTH_FB);
        x = lateral_offset(z, cx - $signed(64'(cfg_cx)), cfg_fx);
        y = lateral_offset(z, cy - $signed(64'(cfg_cy)), cfg_fy);
        pt.point_x = x[31:0];
        pt.point_y = y[31:0];
        pt.point_z = z[31:0];
        pt.point_valid = valid;
        return pt;
    endfunction

    // Value a register should read back, from the predictor copy
    function automatic logic [31:0] cfg_readback(input reg_idx_t idx);
        logic [31:0] v;
        case (idx)
            REG_FOCAL_X:     v = 32'(cfg_fx);
            REG_FOCAL_Y:     v = 32'(cfg_fy);
            REG_CENTER_X:    v = 32'(cfg_cx);
            REG_CENTER_Y:    v = 32'(cfg_cy);
            REG_BASELINE:    v = 32'(cfg_base);
            REG_MAP_WIDTH:   v = 32'(cfg_width);
            REG_MAP_HEIGHT:  v = 32'(cfg_height);
            REG_RANGE_LIMIT: v = 32'(cfg_limit);
            default:         v = '0;
        endcase
        return v;
    endfunction

    // APB write: setup then access, then read the register back
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(idx) << 2; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_FOCAL_X:     cfg_fx = value[15:0];
            REG_FOCAL_Y:     cfg_fy = value[15:0];
            REG_CENTER_X:    cfg_cx = value[15:0];
            REG_CENTER_Y:    cfg_cy = value[15:0];
            REG_BASELINE:    cfg_base = value[17:0];
            REG_MAP_WIDTH:   cfg_width = value[12:0];
            REG_MAP_HEIGHT:  cfg_height = value[12:0];
            REG_RANGE_LIMIT: cfg_limit = value[10:0];
            default: ;
        endcase
        @(posedge aclk);
        if (prdata !== cfg_readback(idx) || pready !== 1'b1) begin
            mismatches++;
            if (mismatches <= 10)
                $display("register %0d read-back: expected %h, got %h ready %b",
                         idx, cfg_readback(idx), prdata, pready);
        end
    endtask

    task automatic write_all(input logic [15:0] fx, input logic [15:0] fy,
            input logic [15:0] cx, input logic [15:0] cy, input logic [17:0] base,
            input logic [12:0] w, input logic [12:0] h, input logic [10:0] lim);
        write_reg(REG_FOCAL_X, 32'(fx));
        write_reg(REG_FOCAL_Y, 32'(fy));
        write_reg(REG_CENTER_X, 32'(cx));
        write_reg(REG_CENTER_Y, 32'(cy));
        write_reg(REG_BASELINE, 32'(base));
        write_reg(REG_MAP_WIDTH, 32'(w));
        write_reg(REG_MAP_HEIGHT, 32'(h));
        write_reg(REG_RANGE_LIMIT, 32'(lim));
    endtask

    // Send one keypoint, with occasional idle cycles before it unless calm
    task automatic send_keypoint(input keypoint_t kp, input logic has_point, input point_t pt,
            input bit calm);
        if (!calm && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_tdata <= kp;
        s_tvalid <= 1'b1;
        pending_points = {pending_points, (has_point ? pt : backproject(kp))};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain;
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_points.size() != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Random keypoint: mostly in the map, some anywhere
    function automatic keypoint_t random_keypoint();
        keypoint_t kp;
        int wl, hl;
        wl = int'(cfg_width) * 16;
        hl = int'(cfg_height) * 16;
        kp = 112'({$urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(9) < 8) begin
            kp.coord_x = 16'((wl > 32767) ? $urandom_range(32767) : $urandom_range(wl - 1));
            kp.coord_y = 16'((hl > 32767) ? $urandom_range(32767) : $urandom_range(hl - 1));
            if ($urandom_range(3) == 0) kp.coord_x = 16'($urandom_range(1) ? 0 : wl - 1);
            if ($urandom_range(3) == 0) kp.coord_y = 16'($urandom_range(1) ? 0 : hl - 1);
            if ($urandom_range(2) != 0)
                kp.disp_center = 16'($urandom_range(int'(cfg_limit) * 16 + 16, 1));
            else if ($urandom_range(1))
                kp.disp_center = -$signed(16'($urandom_range(64)));
            if ($urandom_range(1)) begin
                kp.disp_left  = 16'($urandom_range(2000));
                kp.disp_up    = 16'($urandom_range(2000));
                kp.disp_right = 16'($urandom_range(2000));
                kp.disp_down  = 16'($urandom_range(2000));
            end
        end
        return kp;
    endfunction

    // Check each result transfer against the oldest expectation
    always @(posedge aclk) begin
        point_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata};
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point %h", got);
            end else begin
                want = pending_points.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("point mismatch: expected x=%h y=%h z=%h v=%b, got x=%h y=%h z=%h v=%b",
                                 want.point_x, want.point_y, want.point_z, want.point_valid,
                                 got.point_x, got.point_y, got.point_z, got.point_valid);
                end
            end
        end
    end

    // Result-side backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= rx_quiet ? 1'b1 : ($urandom_range(99) >= 6);
        end
    end

    initial begin
        directed_row_t rows[$];
        directed_row_t r;
        keypoint_t kp;
        point_t zero_pt;
        int phase;

        aresetn = 1'b0;
        s_tdata = '0; s_tvalid = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        mismatches = 0;
        rx_quiet = 1'b0;
        zero_pt = '0;
        cfg_fx = 11502; cfg_fy = 11502; cfg_cx = 9715; cfg_cy = 2963;
        cfg_base = 35203; cfg_width = 1241; cfg_height = 376; cfg_limit = 1000;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table at reset values; out-of-map rows have a known zero point
        r.has_point = 1'b1; r.pt = zero_pt;
        r.kp = '0; r.kp.coord_x = -1; rows = {rows, r};
        r.kp = '0; r.kp.coord_y = -16'sd32768; rows = {rows, r};
        r.kp = '0; r.kp.coord_x = 16'sd32767; rows = {rows, r};
        r.kp = '0; r.kp.coord_x = 1241 * 16; rows = {rows, r};
        r.kp = '0; r.kp.coord_y = 376 * 16; rows = {rows, r};
        r.has_point = 1'b0;
        r.kp = {16'sd160, 16'sd160, 16'sd160, 16'sd160, 16'sd160, 16'sd0, 16'sd0};
        rows = {rows, r};
        r.kp = {16'sd160, 16'sd160, 16'sd160, 16'sd160, 16'sd0, 16'sd100, 16'sd100};
        rows = {rows, r};
        r.kp = {-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd5, 16'sd200,
                16'sd300};
        rows = {rows, r};
        r.kp = {16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                16'sd6015, 16'sd19855};
        rows = {rows, r};
        r.kp = {16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd400, 16'sd400};
        rows = {rows, r};
        r.kp = {16'sd1, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd400, 16'sd400};
        rows = {rows, r};
        r.kp = {16'sd16000, 16'sd0, 16'sd0, 16'sd0, 16'sd16000, 16'sd15, 16'sd15};
        rows = {rows, r};
        r.kp = {16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16001, 16'sd9715, 16'sd2963};
        rows = {rows, r};
        r.kp = {16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd6000, 16'sd19000};
        rows = {rows, r};
        r.kp = {-16'sd4, -16'sd4, -16'sd4, -16'sd4, 16'sd0, 16'sd20, 16'sd20};
        rows = {rows, r};
        foreach (rows[i])
            send_keypoint(rows[i].kp, rows[i].has_point, rows[i].pt, 1'b0);
        // Hold the sender until every expected point is out
        drain();

        // Phases over several register settings, extremes included
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_all(16'd1, 16'd1, 16'd0, 16'd0, 18'd1, 13'd1, 13'd1, 11'd1);
                1: write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 18'h3FFFF,
                             13'd4096, 13'd4096, 11'd2047);
                2: write_all(16'd0, 16'd0, 16'd100, 16'd100, 18'd0, 13'd64, 13'd32, 11'd50);
                3: write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                             18'($urandom_range(262143, 1)),
                             13'($urandom_range(4096, 1)), 13'($urandom_range(4096, 1)),
                             11'($urandom_range(2047, 1)));
                4: write_all(16'd8000, 16'd7000, 16'd5000, 16'd3000, 18'd20000,
                             13'd640, 13'd480, 11'd200);
                default: write_all(16'd11502, 16'd11502, 16'd9715, 16'd2963, 18'd35203,
                                   13'd1241, 13'd376, 11'd1000);
            endcase
            rx_quiet = (phase == 4);
            repeat (175) begin
                kp = random_keypoint();
                send_keypoint(kp, 1'b0, zero_pt, phase == 4);
            end
            drain();
        end

        if (mismatches == 0 && pending_points.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ stereo_disparity_backprojection_unit.f @@
+incdir+sv
sv/sdb_pkg.sv
sv/sdb_fifo.sv
sv/sdb_div.sv
sv/sdb_front.sv
sv/sdb_back.sv
sv/stereo_disparity_backprojection_unit.sv
sv/sdb_checker.sv
dv/tb_stereo_disparity_backprojection_unit.sv
